>>> hw/rtl/wwsr_pkg.sv
// ----------------------------------------------------------------------------
// wwsr_pkg
// Shared types, codes and defaults for the waypoint window resend block.
// ----------------------------------------------------------------------------
package wwsr_pkg;

  localparam int WindowLog2Def   = 3;
  localparam int CoordBitsDef    = 16;
  localparam int PendingDepthDef = 64;

  localparam int CoordW  = 16;
  localparam int IdxW    = 3;
  localparam int CodeW   = 8;
  localparam int ReqW    = 2;
  localparam int KindW   = 2;
  localparam int RegIdxW = 1;

  typedef enum logic [ReqW-1:0] {
    REQ_LOAD     = 2'd0,
    REQ_SEND     = 2'd1,
    REQ_PT_ECHO  = 2'd2,
    REQ_DEF_ECHO = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    MK_NOT_SENT = 2'd0,
    MK_SENT     = 2'd1,
    MK_WAIT     = 2'd2,
    MK_VALID    = 2'd3
  } mark_e;

  typedef enum logic [KindW-1:0] {
    KIND_POS   = 2'd0,
    KIND_POINT = 2'd1,
    KIND_CODE  = 2'd2
  } kind_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_END_OF_SET = 1'b0,
    REG_NEXT_SET   = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    DEC_SEND_NS,
    DEC_END_CODE,
    DEC_END_WAIT,
    DEC_CLEAR,
    DEC_PULL,
    DEC_RESEND_ONE,
    DEC_RESEND
  } dec_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_FILL_RD,
    S_FILL_WR,
    S_SCAN,
    S_DECIDE,
    S_EMIT,
    S_ECHO
  } state_e;

  typedef struct packed {
    logic [ReqW-1:0]   req_type;
    logic [CoordW-1:0] point_x;
    logic [CoordW-1:0] point_y;
    logic [IdxW-1:0]   reply_index;
    logic [CodeW-1:0]  reply_default;
    logic              reply_has_default;
  } item_t;

  typedef struct packed {
    logic [KindW-1:0]  frame_kind;
    logic [IdxW-1:0]   sent_index;
    logic [CoordW-1:0] sent_x;
    logic [CoordW-1:0] sent_y;
    logic [CodeW-1:0]  sent_default;
    logic              overflow_seen;
  } result_t;

  typedef struct packed {
    logic take;
    logic load;
    logic def_echo;
    logic echo_rd;
    logic echo_cmp;
    logic fill_rd;
    logic fill_wr;
    logic end_reset;
    logic scan_clr;
    logic scan_step;
    logic apply;
    logic set_pos;
    logic emit;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic pend_empty;
    logic win_empty;
    logic win_full;
    logic scan_last;
    logic reload;
    dec_e dec;
  } status_t;

endpackage

>>> hw/rtl/wwsr_ctrl.sv
// ----------------------------------------------------------------------------
// wwsr_ctrl
// Sequencer: dispatches each transaction and steps fill, scan and send.
// ----------------------------------------------------------------------------
module wwsr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  wwsr_pkg::status_t status_i,
  output wwsr_pkg::cmd_t    cmd_o
);
  import wwsr_pkg::*;

  state_e state_q, state_d;
  logic   depth_q, depth_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      depth_q <= 1'b0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
    end
  end

  always_comb begin
    state_d = state_q;
    depth_d = depth_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.take = 1'b1;
          depth_d    = 1'b0;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status_i.req)
          REQ_LOAD: begin
            cmd_o.load = 1'b1;
            state_d    = S_IDLE;
          end
          REQ_DEF_ECHO: begin
            cmd_o.def_echo = 1'b1;
            state_d        = S_IDLE;
          end
          REQ_PT_ECHO: begin
            cmd_o.echo_rd = 1'b1;
            state_d       = S_ECHO;
          end
          REQ_SEND: begin
            if (status_i.pend_empty && status_i.win_empty) begin
              cmd_o.set_pos = 1'b1;
              state_d       = S_EMIT;
            end else if (status_i.win_empty) begin
              state_d = S_FILL_RD;
            end else begin
              cmd_o.scan_clr = 1'b1;
              state_d        = S_SCAN;
            end
          end
        endcase
      end
      S_FILL_RD: begin
        cmd_o.end_reset = 1'b1;
        if (!status_i.pend_empty && !status_i.win_full) begin
          cmd_o.fill_rd = 1'b1;
          state_d       = S_FILL_WR;
        end else begin
          cmd_o.scan_clr = 1'b1;
          state_d        = status_i.win_empty ? S_DECIDE : S_SCAN;
        end
      end
      S_FILL_WR: begin
        cmd_o.fill_wr = 1'b1;
        state_d       = S_FILL_RD;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.apply = 1'b1;
        if (status_i.dec == DEC_CLEAR && status_i.reload && !depth_q) begin
          depth_d = 1'b1;
          state_d = S_FILL_RD;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end
      S_ECHO: begin
        cmd_o.echo_cmp = 1'b1;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

>>> hw/rtl/wwsr_datapath.sv
// ----------------------------------------------------------------------------
// wwsr_datapath
// Pending FIFO, window store, mark flags, mark scan and result register.
// ----------------------------------------------------------------------------
module wwsr_datapath #(
  parameter int WINDOW_LOG2   = wwsr_pkg::WindowLog2Def,
  parameter int COORD_BITS    = wwsr_pkg::CoordBitsDef,
  parameter int PENDING_DEPTH = wwsr_pkg::PendingDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  wwsr_pkg::item_t              item_i,
  input  logic                         cfg_we_i,
  input  logic [wwsr_pkg::RegIdxW-1:0] cfg_idx_i,
  input  logic [wwsr_pkg::CodeW-1:0]   cfg_wdata_i,
  input  wwsr_pkg::cmd_t               cmd_i,
  output wwsr_pkg::status_t            status_o,
  output logic                         done_o,
  output wwsr_pkg::result_t            result_o
);
  import wwsr_pkg::*;

  localparam int Window    = 1 << WINDOW_LOG2;
  localparam int WcW       = WINDOW_LOG2 + 1;
  localparam int StoreBits = (COORD_BITS < CoordW) ? COORD_BITS : CoordW;
  localparam int PtW       = $clog2(PENDING_DEPTH);
  localparam int CntW      = $clog2(PENDING_DEPTH + 1);
  localparam int IdxExtW   = (WINDOW_LOG2 > IdxW) ? WINDOW_LOG2 : IdxW;
  localparam int RiCmpW    = (WcW > IdxW) ? WcW : IdxW;
  localparam int PointW    = 2 * StoreBits;

  function automatic logic [PtW-1:0] ptr_inc(input logic [PtW-1:0] p);
    return (p == PtW'(PENDING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  item_t                  item_q;
  logic [CodeW-1:0]       eos_q, nxt_q;
  logic [PtW-1:0]         head_q, tail_q;
  logic [CntW-1:0]        pcount_q;
  logic [PointW-1:0]      pend_mem [PENDING_DEPTH];
  logic [PointW-1:0]      pend_rdata_q;
  logic [PointW-1:0]      win_mem [Window];
  logic [PointW-1:0]      win_rdata_q;
  logic [WINDOW_LOG2-1:0] win_raddr;
  logic [WcW-1:0]         wcount_q;
  mark_e                  marks_q [Window];
  mark_e                  marks_d [Window];
  mark_e                  end_mark_q;
  logic [CodeW:0]         end_code_q;
  logic                   overflow_q;

  logic [WcW-1:0]         scan_i_q;
  logic                   ns_found_q, sent_found_q, uv_found_q, uv_wait_q, uv_many_q;
  logic [WINDOW_LOG2-1:0] ns_idx_q, sent_idx_q, uv_idx_q;
  mark_e                  scan_mark;
  logic [WINDOW_LOG2-1:0] scan_idx;

  kind_e                  kind_q;
  logic [WINDOW_LOG2-1:0] idx_q;
  logic [CodeW-1:0]       code_q;
  result_t                out_q;
  result_t                out_d;
  logic                   done_q;

  dec_e                   dec;
  logic [WINDOW_LOG2-1:0] sel_idx;
  logic                   pend_full;
  logic [CodeW-1:0]       end_code_sel;
  logic [RiCmpW-1:0]      ri_ext, wc_ext;
  logic [WINDOW_LOG2-1:0] echo_addr;
  logic                   echo_hit;
  logic [IdxExtW-1:0]     idx_ext;
  logic [PointW-1:0]      echo_point;

  assign pend_full    = (pcount_q == CntW'(PENDING_DEPTH));
  assign end_code_sel = (pcount_q == '0) ? eos_q : nxt_q;
  assign ri_ext       = RiCmpW'(item_q.reply_index);
  assign wc_ext       = RiCmpW'(wcount_q);
  assign echo_addr    = ri_ext[WINDOW_LOG2-1:0];
  assign echo_point   = {item_q.point_x[StoreBits-1:0], item_q.point_y[StoreBits-1:0]};
  assign echo_hit     = (ri_ext < wc_ext) && (win_rdata_q == echo_point);
  assign scan_idx     = scan_i_q[WINDOW_LOG2-1:0];
  assign scan_mark    = marks_q[scan_idx];
  assign win_raddr    = cmd_i.echo_rd ? echo_addr : sel_idx;
  assign idx_ext      = IdxExtW'(idx_q);

  always_comb begin
    dec     = DEC_RESEND;
    sel_idx = uv_idx_q;
    if (ns_found_q) begin
      dec     = DEC_SEND_NS;
      sel_idx = ns_idx_q;
    end else if (!uv_found_q) begin
      sel_idx = '0;
      case (end_mark_q)
        MK_VALID: dec = DEC_CLEAR;
        MK_SENT:  dec = DEC_END_WAIT;
        default:  dec = DEC_END_CODE;
      endcase
    end else if (!uv_many_q) begin
      dec = uv_wait_q ? DEC_RESEND_ONE : DEC_PULL;
    end else if (sent_found_q) begin
      sel_idx = sent_idx_q;
    end
  end

  always_comb begin
    marks_d = marks_q;
    if (cmd_i.fill_wr) begin
      marks_d[wcount_q[WINDOW_LOG2-1:0]] = MK_NOT_SENT;
    end
    if (cmd_i.echo_cmp && echo_hit) begin
      marks_d[echo_addr] = MK_VALID;
    end
    if (cmd_i.apply) begin
      case (dec) inside
        DEC_SEND_NS, DEC_RESEND_ONE: marks_d[sel_idx] = MK_SENT;
        DEC_PULL: marks_d[sel_idx] = MK_WAIT;
        DEC_CLEAR: begin
          for (int i = 0; i < Window; i++) begin
            marks_d[i] = MK_NOT_SENT;
          end
        end
        DEC_RESEND: begin
          for (int i = 0; i < Window; i++) begin
            if (marks_q[i] == MK_SENT) begin
              marks_d[i] = MK_NOT_SENT;
            end
          end
          marks_d[sel_idx] = MK_SENT;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_d               = '0;
    out_d.frame_kind    = kind_q;
    out_d.overflow_seen = overflow_q;
    if (kind_q == KIND_POINT) begin
      out_d.sent_index = idx_ext[IdxW-1:0];
      out_d.sent_x     = CoordW'(win_rdata_q[PointW-1:StoreBits]);
      out_d.sent_y     = CoordW'(win_rdata_q[StoreBits-1:0]);
    end
    if (kind_q == KIND_CODE) begin
      out_d.sent_default = code_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      item_q <= item_i;
    end
    if (cmd_i.load && !pend_full) begin
      pend_mem[tail_q] <= echo_point;
    end
    if (cmd_i.fill_rd) begin
      pend_rdata_q <= pend_mem[head_q];
    end
    if (cmd_i.fill_wr) begin
      win_mem[wcount_q[WINDOW_LOG2-1:0]] <= pend_rdata_q;
    end
    win_rdata_q <= win_mem[win_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Window; i++) begin
        marks_q[i] <= MK_NOT_SENT;
      end
    end else begin
      marks_q <= marks_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eos_q        <= '0;
      nxt_q        <= CodeW'(1);
      head_q       <= '0;
      tail_q       <= '0;
      pcount_q     <= '0;
      wcount_q     <= '0;
      end_mark_q   <= MK_NOT_SENT;
      end_code_q   <= {1'b1, {CodeW{1'b0}}};
      overflow_q   <= 1'b0;
      scan_i_q     <= '0;
      ns_found_q   <= 1'b0;
      sent_found_q <= 1'b0;
      uv_found_q   <= 1'b0;
      uv_wait_q    <= 1'b0;
      uv_many_q    <= 1'b0;
      ns_idx_q     <= '0;
      sent_idx_q   <= '0;
      uv_idx_q     <= '0;
      kind_q       <= KIND_POS;
      idx_q        <= '0;
      code_q       <= '0;
      done_q       <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
      if (cfg_we_i) begin
        unique case (reg_e'(cfg_idx_i))
          REG_END_OF_SET: eos_q <= cfg_wdata_i;
          REG_NEXT_SET:   nxt_q <= cfg_wdata_i;
        endcase
      end
      if (cmd_i.load) begin
        if (pend_full) begin
          overflow_q <= 1'b1;
        end else begin
          tail_q   <= ptr_inc(tail_q);
          pcount_q <= pcount_q + 1'b1;
        end
      end
      if (cmd_i.fill_rd) begin
        head_q   <= ptr_inc(head_q);
        pcount_q <= pcount_q - 1'b1;
      end
      if (cmd_i.fill_wr) begin
        wcount_q <= wcount_q + 1'b1;
      end
      if (cmd_i.end_reset) begin
        end_mark_q <= MK_NOT_SENT;
      end
      if (cmd_i.def_echo && item_q.reply_has_default &&
          ({1'b0, item_q.reply_default} == end_code_q)) begin
        end_mark_q <= MK_VALID;
      end
      if (cmd_i.scan_clr) begin
        scan_i_q     <= '0;
        ns_found_q   <= 1'b0;
        sent_found_q <= 1'b0;
        uv_found_q   <= 1'b0;
        uv_wait_q    <= 1'b0;
        uv_many_q    <= 1'b0;
      end else if (cmd_i.scan_step) begin
        scan_i_q <= scan_i_q + 1'b1;
        if (scan_mark == MK_NOT_SENT && !ns_found_q) begin
          ns_found_q <= 1'b1;
          ns_idx_q   <= scan_idx;
        end
        if (scan_mark == MK_SENT && !sent_found_q) begin
          sent_found_q <= 1'b1;
          sent_idx_q   <= scan_idx;
        end
        if (scan_mark != MK_VALID) begin
          if (!uv_found_q) begin
            uv_found_q <= 1'b1;
            uv_idx_q   <= scan_idx;
            uv_wait_q  <= (scan_mark == MK_WAIT);
          end else begin
            uv_many_q <= 1'b1;
          end
        end
      end
      if (cmd_i.set_pos) begin
        kind_q <= KIND_POS;
      end
      if (cmd_i.apply) begin
        idx_q <= sel_idx;
        case (dec)
          DEC_END_CODE: begin
            end_mark_q <= MK_SENT;
            end_code_q <= {1'b0, end_code_sel};
            code_q     <= end_code_sel;
            kind_q     <= KIND_CODE;
          end
          DEC_END_WAIT: begin
            end_mark_q <= MK_WAIT;
            kind_q     <= KIND_POS;
          end
          DEC_CLEAR: begin
            wcount_q <= '0;
            kind_q   <= KIND_POS;
          end
          DEC_PULL: kind_q <= KIND_POS;
          default:  kind_q <= KIND_POINT;
        endcase
      end
    end
  end

  assign status_o.req        = req_e'(item_q.req_type);
  assign status_o.pend_empty = (pcount_q == '0);
  assign status_o.win_empty  = (wcount_q == '0);
  assign status_o.win_full   = (wcount_q == WcW'(Window));
  assign status_o.scan_last  = ((scan_i_q + 1'b1) == wcount_q);
  assign status_o.reload     = (end_code_q == {1'b0, nxt_q});
  assign status_o.dec        = dec;

  assign done_o   = done_q;
  assign result_o = out_q;

  a_pcount_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcount_q <= CntW'(PENDING_DEPTH))
    else $error("pending count past depth");

  a_wcount_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wcount_q <= WcW'(Window))
    else $error("window count past window size");

  a_fill_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fill_wr |-> (wcount_q != WcW'(Window)) && $past(cmd_i.fill_rd))
    else $error("window write without a room or a FIFO read");

  a_fill_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fill_rd |-> (pcount_q != '0))
    else $error("FIFO read while empty");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for two cycles");

endmodule

>>> hw/rtl/waypoint_window_selective_resend.sv
// ----------------------------------------------------------------------------
// waypoint_window_selective_resend
// Load and default echo finish at dispatch; point echo reads the window, then compares.
// Send: the window entries are scanned one per cycle, then a decision is applied and
//   the result emitted; an empty window is first filled from the FIFO, each point read
//   and then written, and a validated next-set code adds a refill and a second scan.
// Nothing pending: a position frame is emitted. Results cannot be stalled.
// Reset: asynchronous, clears counts, marks, flags and codes; stores need no clearing pass.
// ----------------------------------------------------------------------------
module waypoint_window_selective_resend #(
  parameter int WINDOW_LOG2   = wwsr_pkg::WindowLog2Def,
  parameter int COORD_BITS    = wwsr_pkg::CoordBitsDef,
  parameter int PENDING_DEPTH = wwsr_pkg::PendingDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  wwsr_pkg::item_t              item_i,
  output logic                         done_o,
  output wwsr_pkg::result_t            result_o,
  input  logic                         cfg_we_i,
  input  logic [wwsr_pkg::RegIdxW-1:0] cfg_idx_i,
  input  logic [wwsr_pkg::CodeW-1:0]   cfg_wdata_i
);
  import wwsr_pkg::*;

  cmd_t    cmd;
  status_t status;

  wwsr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  wwsr_datapath #(
    .WINDOW_LOG2   (WINDOW_LOG2),
    .COORD_BITS    (COORD_BITS),
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .done_o      (done_o),
    .result_o    (result_o)
  );

endmodule
